@@ src/oahm_pkg.sv @@
// Shared widths, codes and constants of the open-address hash map.
package oahm_pkg;

  localparam int FUNC_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int PID_W      = 22;
  localparam int TIME_W     = 40;
  localparam int CFG_W      = 8;
  localparam int HASH_SHIFT = 6;

  localparam int SHIFTED_W  = PID_W + HASH_SHIFT;
  localparam int SEED_W     = ((SHIFTED_W > TIME_W) ? SHIFTED_W : TIME_W) + 1;
  localparam int MOD_BITS   = 4;
  localparam int MOD_STEPS  = (SEED_W + MOD_BITS - 1) / MOD_BITS;
  localparam int SEED_PAD_W = MOD_STEPS * MOD_BITS;
  localparam int MOD_CNT_W  = $clog2(MOD_STEPS);

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd101;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_DELETE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_LIVE    = 2'd1,
    ST_DELETED = 2'd2
  } slot_state_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_DONE = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } res_status_e;

endpackage

@@ src/oahm_slot_mem.sv @@
// Synchronous slot memory: one write port, one registered read port.
module oahm_slot_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 75
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/oahm_mod_unit.sv @@
// Iterative remainder unit: hash seed modulo the table size, four bits a cycle.
module oahm_mod_unit
  import oahm_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [SEED_W-1:0]                seed_i,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] size_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   rem_o
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int SIZE_W = $clog2(TABLE_DEPTH + 1);
  localparam int RW     = SIZE_W + 1;

  logic                  busy_q;
  logic [MOD_CNT_W-1:0]  cnt_q;
  logic [SEED_PAD_W-1:0] seed_q, seed_d;
  logic [RW-1:0]         r_q, r_d;

  always_comb begin
    r_d    = r_q;
    seed_d = seed_q;
    for (int k = 0; k < MOD_BITS; k++) begin
      r_d    = {r_d[RW-2:0], seed_d[SEED_PAD_W-1]};
      seed_d = seed_d << 1;
      if (r_d >= RW'(size_i)) begin
        r_d = r_d - RW'(size_i);
      end
    end
  end

  assign done_o = busy_q && (cnt_q == MOD_CNT_W'(MOD_STEPS - 1));
  assign rem_o  = r_d[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      seed_q <= '0;
      r_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      seed_q <= SEED_PAD_W'(seed_i);
      r_q    <= '0;
    end else if (busy_q) begin
      seed_q <= seed_d;
      r_q    <= r_d;
      cnt_q  <= cnt_q + MOD_CNT_W'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/oahm_probe.sv @@
// Probe sequencer: clearing pass, linear probing, slot update and result register.
module oahm_probe
  import oahm_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  parameter int REC_W       = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] size_i,
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [FUNC_W-1:0]                s_func_i,
  input  logic [PID_W-1:0]                 s_pid_i,
  input  logic [TIME_W-1:0]                s_time_i,
  input  logic [REC_W-1:0]                 s_rec_i,
  output logic                             m_valid_o,
  input  logic                             m_ready_i,
  output logic [STATUS_W-1:0]              m_status_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   m_slot_o,
  output logic [REC_W-1:0]                 m_rec_o,
  input  logic                             mod_done_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   mod_rem_i,
  output logic                             mem_we_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_waddr_o,
  output logic [2+PID_W+TIME_W+REC_W-1:0]  mem_wdata_o,
  output logic                             mem_re_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_raddr_o,
  input  logic [2+PID_W+TIME_W+REC_W-1:0]  mem_rdata_i
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = 2 + PID_W + TIME_W + REC_W;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_FINISH
  } state_e;

  state_e              state_q;
  logic [AW-1:0]       clr_q;
  func_e               op_q;
  logic [PID_W-1:0]    pid_q;
  logic [TIME_W-1:0]   time_q;
  logic [REC_W-1:0]    rec_q;
  logic [AW-1:0]       pos_q;
  logic [SIZE_W-1:0]   cnt_q;
  res_status_e         res_status_q;
  logic [AW-1:0]       res_slot_q;
  logic [REC_W-1:0]    res_rec_q;
  logic                m_valid_q;
  res_status_e         m_status_q;
  logic [AW-1:0]       m_slot_q;
  logic [REC_W-1:0]    m_rec_q;

  slot_state_e         ent_st;
  logic [PID_W-1:0]    ent_pid;
  logic [TIME_W-1:0]   ent_time;
  logic [REC_W-1:0]    ent_rec;
  logic                key_eq;
  logic                last_probe;
  logic [SIZE_W-1:0]   pos_inc;
  logic [AW-1:0]       next_pos;
  logic                chk_stop;
  logic                chk_write;
  slot_state_e         chk_wstate;
  res_status_e         chk_status;
  logic [AW-1:0]       chk_slot;
  logic [REC_W-1:0]    chk_rec;

  assign ent_st   = slot_state_e'(mem_rdata_i[ENTRY_W-1 -: 2]);
  assign ent_pid  = mem_rdata_i[REC_W+TIME_W +: PID_W];
  assign ent_time = mem_rdata_i[REC_W +: TIME_W];
  assign ent_rec  = mem_rdata_i[REC_W-1:0];

  assign key_eq     = (ent_pid == pid_q) && (ent_time == time_q);
  assign last_probe = (cnt_q + SIZE_W'(1)) == size_i;
  assign pos_inc    = SIZE_W'(pos_q) + SIZE_W'(1);
  assign next_pos   = (pos_inc == size_i) ? '0 : pos_inc[AW-1:0];

  always_comb begin
    chk_stop   = 1'b0;
    chk_write  = 1'b0;
    chk_wstate = ST_LIVE;
    chk_status = RES_MISS;
    chk_slot   = '0;
    chk_rec    = '1;
    case (op_q)
      FUNC_INSERT: begin
        if (ent_st != ST_LIVE || key_eq) begin
          chk_stop   = 1'b1;
          chk_write  = 1'b1;
          chk_status = RES_DONE;
          chk_slot   = pos_q;
        end else if (last_probe) begin
          chk_stop   = 1'b1;
          chk_status = RES_FULL;
        end
      end
      FUNC_FIND, FUNC_DELETE: begin
        if (ent_st == ST_EMPTY) begin
          chk_stop = 1'b1;
        end else if (ent_st == ST_LIVE && key_eq) begin
          chk_stop   = 1'b1;
          chk_write  = (op_q == FUNC_DELETE);
          chk_wstate = ST_DELETED;
          chk_status = RES_DONE;
          chk_slot   = pos_q;
          chk_rec    = ent_rec;
        end else if (last_probe) begin
          chk_stop = 1'b1;
        end
      end
      default: begin
        chk_stop = 1'b1;
      end
    endcase
  end

  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = {ST_LIVE, pid_q, time_q, rec_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = pos_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = {ST_EMPTY, {(ENTRY_W-2){1'b0}}};
      end
      S_READ: begin
        mem_re_o = 1'b1;
      end
      S_CHECK: begin
        mem_we_o = chk_write;
        if (chk_wstate == ST_DELETED) begin
          mem_wdata_o = {ST_DELETED, mem_rdata_i[ENTRY_W-3:0]};
        end
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  assign s_ready_o  = (state_q == S_IDLE);
  assign m_valid_o  = m_valid_q;
  assign m_status_o = m_status_q;
  assign m_slot_o   = m_slot_q;
  assign m_rec_o    = m_rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      op_q         <= FUNC_FIND;
      pid_q        <= '0;
      time_q       <= '0;
      rec_q        <= '0;
      pos_q        <= '0;
      cnt_q        <= '0;
      res_status_q <= RES_MISS;
      res_slot_q   <= '0;
      res_rec_q    <= '1;
      m_valid_q    <= 1'b0;
      m_status_q   <= RES_MISS;
      m_slot_q     <= '0;
      m_rec_q      <= '1;
    end else begin
      if (m_valid_q && m_ready_i && state_q != S_FINISH) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(TABLE_DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_valid_i) begin
            pid_q  <= s_pid_i;
            time_q <= s_time_i;
            rec_q  <= s_rec_i;
            case (s_func_i) inside
              FUNC_INSERT, FUNC_FIND, FUNC_DELETE: begin
                op_q    <= func_e'(s_func_i);
                state_q <= S_HASH;
              end
              default: begin
                res_status_q <= RES_MISS;
                res_slot_q   <= '0;
                res_rec_q    <= '1;
                state_q      <= S_FINISH;
              end
            endcase
          end
        end
        S_HASH: begin
          if (mod_done_i) begin
            pos_q   <= mod_rem_i;
            cnt_q   <= '0;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (chk_stop) begin
            res_status_q <= chk_status;
            res_slot_q   <= chk_slot;
            res_rec_q    <= chk_rec;
            state_q      <= S_FINISH;
          end else begin
            pos_q   <= next_pos;
            cnt_q   <= cnt_q + SIZE_W'(1);
            state_q <= S_READ;
          end
        end
        S_FINISH: begin
          if (!m_valid_q || m_ready_i) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_slot_q   <= res_slot_q;
            m_rec_q    <= res_rec_q;
            state_q    <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we_o)
    else $error("slot memory written while idle");

  a_mod_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done_i |-> state_q == S_HASH)
    else $error("remainder finished outside hash wait");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> cnt_q < size_i)
    else $error("probe count reached table size");

  a_no_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !m_valid_q && !s_ready_o)
    else $error("activity during clearing pass");
`endif

endmodule

@@ src/open_address_hash_map.sv @@
// Top level of the open-address hash map: stream ports, size register, unit wiring.
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser func, tdata key and record
//  m_axis    out        m_axis_tvalid/m_axis_tready  tuser status, tdata slot and record
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_data_i table size
//
// An item passes the accept state, the remainder unit (4 seed bits a cycle over a
// 41-bit seed), a read and a check state per probe on the single-read slot memory
// and the result register.
// After reset a clearing pass over all TABLE_DEPTH slots holds s_axis_tready low.
// One finished item waits in the result register while the next is accepted.
module open_address_hash_map
  import oahm_pkg::*;
#(
  parameter int TABLE_DEPTH  = 128,
  parameter int RECORD_COUNT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // proc_id, start_time, record_index; zero padded to bytes
  input  logic [((PID_W+TIME_W+$clog2(RECORD_COUNT)+1+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [FUNC_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // slot, found_record; zero padded to bytes
  output logic [(($clog2(TABLE_DEPTH)+$clog2(RECORD_COUNT)+1+7)/8)*8-1:0] m_axis_tdata,
  // status
  output logic [STATUS_W-1:0]   m_axis_tuser,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  localparam int AW      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W  = $clog2(TABLE_DEPTH + 1);
  localparam int REC_W   = $clog2(RECORD_COUNT) + 1;
  localparam int ENTRY_W = 2 + PID_W + TIME_W + REC_W;
  localparam int OUT_W   = ((AW + REC_W + 7) / 8) * 8;
  localparam int CMP_W   = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  logic [CFG_W-1:0]   cfg_q;
  logic [CMP_W-1:0]   cfg_ext;
  logic [SIZE_W-1:0]  size_use;
  logic [PID_W-1:0]   in_pid;
  logic [TIME_W-1:0]  in_time;
  logic [REC_W-1:0]   in_rec;
  logic [SEED_W-1:0]  seed;
  logic               mod_start;
  logic               mod_done;
  logic [AW-1:0]      mod_rem;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [AW-1:0]      out_slot;
  logic [REC_W-1:0]   out_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_ext     = CMP_W'(cfg_q);

  always_comb begin
    if (cfg_q == '0) begin
      size_use = SIZE_W'(1);
    end else if (cfg_ext > CMP_W'(TABLE_DEPTH)) begin
      size_use = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_use = SIZE_W'(cfg_ext);
    end
  end

  assign in_pid    = s_axis_tdata[PID_W-1:0];
  assign in_time   = s_axis_tdata[PID_W +: TIME_W];
  assign in_rec    = s_axis_tdata[PID_W+TIME_W +: REC_W];
  assign seed      = SEED_W'({in_pid, {HASH_SHIFT{1'b0}}}) + SEED_W'(in_time);
  assign mod_start = s_axis_tvalid && s_axis_tready &&
                     (s_axis_tuser inside {FUNC_INSERT, FUNC_FIND, FUNC_DELETE});

  oahm_mod_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mod_start),
    .seed_i (seed),
    .size_i (size_use),
    .done_o (mod_done),
    .rem_o  (mod_rem)
  );

  oahm_slot_mem #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  oahm_probe #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .REC_W      (REC_W)
  ) u_probe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_use),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_func_i   (s_axis_tuser),
    .s_pid_i    (in_pid),
    .s_time_i   (in_time),
    .s_rec_i    (in_rec),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_status_o (m_axis_tuser),
    .m_slot_o   (out_slot),
    .m_rec_o    (out_rec),
    .mod_done_i (mod_done),
    .mod_rem_i  (mod_rem),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  assign m_axis_tdata = OUT_W'({out_rec, out_slot});

endmodule
